### sv/fenp_pkg.sv
// ----------------------------------------------------------------------------
// fenp_pkg
// Shared types and constants for the FEN position parser: parse phases,
// character codes and the parser state record.
// ----------------------------------------------------------------------------
package fenp_pkg;

  localparam int PlaneCount = 8;
  localparam int PlaneWhite = 6;
  localparam int PlaneOcc   = 7;

  localparam logic [7:0]  StartSquare = 8'd56;
  localparam logic [7:0]  RankDrop    = 8'd16;
  localparam logic [7:0]  LastRankEnd = 8'd8;
  localparam logic [6:0]  NoSquare    = 7'd64;
  localparam logic [9:0]  ClockMax    = 10'd1023;
  localparam logic [2:0]  CastleSkip  = 3'd7;
  localparam logic [2:0]  CastleLimit = 3'd4;

  // character codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChEight = 8'h38;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoH   = 8'h68;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] ChW     = 8'h77;
  localparam logic [7:0] ChUpK   = 8'h4B;
  localparam logic [7:0] ChUpQ   = 8'h51;
  localparam logic [7:0] ChLoK   = 8'h6B;
  localparam logic [7:0] ChLoQ   = 8'h71;
  localparam logic [7:0] ChLoP   = 8'h70;
  localparam logic [7:0] ChLoN   = 8'h6E;
  localparam logic [7:0] ChLoB   = 8'h62;
  localparam logic [7:0] ChLoR   = 8'h72;

  typedef enum logic [3:0] {
    PH_LEAD,
    PH_BOARD,
    PH_NEED_SPACE,
    PH_SKIP_TURN,
    PH_SKIP_CASTLE,
    PH_CASTLE,
    PH_SKIP_EP,
    PH_EP_SECOND,
    PH_EP_REST,
    PH_SKIP_HALF,
    PH_HALF,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t                         phase;
    logic [7:0]                     cursor;
    logic [PlaneCount-1:0][63:0]    planes;
    logic                           side;
    logic [3:0]                     castle;
    logic [2:0]                     castle_count;
    logic [7:0]                     ep_file;
    logic [6:0]                     ep_target;
    logic [9:0]                     half_acc;
    logic                           err;
  } parse_state_t;

  function automatic parse_state_t reset_state();
    parse_state_t s;
    s              = '0;
    s.phase        = PH_LEAD;
    s.cursor       = StartSquare;
    s.ep_target    = NoSquare;
    return s;
  endfunction

endpackage

### sv/fen_text_to_bitboard_parser.sv
// ----------------------------------------------------------------------------
// fen_text_to_bitboard_parser
// Parses a FEN position record, one character per item, into bitboards.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle, back to back; the parse state is a
// single register bank updated by a combinational decode of each character.
// The character flagged end_of_record produces one result item in the output
// register in the next cycle, and the parser is cleared for the next record
// in the same cycle, so records may follow each other with no gap. The input
// stalls only while a finished result is waiting and out_ready is low. Any
// format error yields a result with every field zero.
module fen_text_to_bitboard_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        end_of_record,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] pawn_plane,
  output logic [63:0] knight_plane,
  output logic [63:0] bishop_plane,
  output logic [63:0] rook_plane,
  output logic [63:0] queen_plane,
  output logic [63:0] king_plane,
  output logic [63:0] white_plane,
  output logic [63:0] occupied_plane,
  output logic        white_to_move,
  output logic [3:0]  castle_rights,
  output logic [6:0]  en_passant_square,
  output logic [9:0]  half_move_clock
);

  fenp_pkg::parse_state_t st;
  fenp_pkg::parse_state_t st_next;
  logic                   in_fire;
  logic                   ok;

  fenp_step u_step (
    .cur       (st),
    .char_code (char_code),
    .nxt       (st_next)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign ok       = !st_next.err &&
                    ((st_next.phase == fenp_pkg::PH_HALF) ||
                     (st_next.phase == fenp_pkg::PH_DONE));

  // update parse state; clear it after the last character of a record
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= fenp_pkg::reset_state();
    end else if (in_fire) begin
      if (end_of_record) st <= fenp_pkg::reset_state();
      else               st <= st_next;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && end_of_record) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // load the result payload, zeroed on error
  always_ff @(posedge clk) begin
    if (in_fire && end_of_record) begin
      pawn_plane        <= ok ? st_next.planes[0] : 64'd0;
      knight_plane      <= ok ? st_next.planes[1] : 64'd0;
      bishop_plane      <= ok ? st_next.planes[2] : 64'd0;
      rook_plane        <= ok ? st_next.planes[3] : 64'd0;
      queen_plane       <= ok ? st_next.planes[4] : 64'd0;
      king_plane        <= ok ? st_next.planes[5] : 64'd0;
      white_plane       <= ok ? st_next.planes[fenp_pkg::PlaneWhite] : 64'd0;
      occupied_plane    <= ok ? st_next.planes[fenp_pkg::PlaneOcc] : 64'd0;
      white_to_move     <= ok ? st_next.side : 1'b0;
      castle_rights     <= ok ? st_next.castle : 4'd0;
      en_passant_square <= ok ? st_next.ep_target : 7'd0;
      half_move_clock   <= ok ? st_next.half_acc : 10'd0;
    end
  end

  // parser restarts from a clean state after each record
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_record |=> (st.phase == fenp_pkg::PH_LEAD) &&
      (st.cursor == fenp_pkg::StartSquare) && !st.err)
    else $error("parser not cleared after end of record");

  // occupied plane is the union of the piece planes
  a_occ_union: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pawn_plane | knight_plane | bishop_plane | rook_plane |
                    queen_plane | king_plane) == occupied_plane))
    else $error("occupied plane differs from piece union");

  // white pieces sit only on occupied squares
  a_white_sub: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((white_plane & ~occupied_plane) == 64'd0))
    else $error("white plane outside occupied squares");

  // en passant square stays in range
  a_ep_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (en_passant_square <= fenp_pkg::NoSquare))
    else $error("en passant square out of range");

  // result item follows the last character
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_record |=> out_valid)
    else $error("no result after end of record");

endmodule

### sv/fenp_step.sv
// ----------------------------------------------------------------------------
// fenp_step
// Next-state logic of the parser: folds one character into the parse state.
// ----------------------------------------------------------------------------
module fenp_step (
  input  fenp_pkg::parse_state_t cur,
  input  logic [7:0]             char_code,
  output fenp_pkg::parse_state_t nxt
);

  logic             is_digit;
  logic             is_alpha;
  logic             is_upper;
  logic [7:0]       lower;
  logic [2:0]       pidx;
  logic             pvalid;
  logic [8:0]       dsum;
  logic [63:0]      sq_bit;
  logic [13:0]      acc_x10;
  logic [14:0]      acc_sum;
  logic [7:0]       rank_ofs;
  logic [7:0]       file_ofs;
  logic             do_board;
  logic             do_castle;

  // classify the character
  always_comb begin
    is_digit = (char_code >= fenp_pkg::ChZero) && (char_code <= fenp_pkg::ChNine);
    is_upper = (char_code >= fenp_pkg::ChUpA) && (char_code <= fenp_pkg::ChUpZ);
    is_alpha = is_upper ||
               ((char_code >= fenp_pkg::ChLoA) && (char_code <= fenp_pkg::ChLoZ));
    lower    = is_upper ? (char_code | 8'h20) : char_code;
    pvalid   = 1'b1;
    case (lower)
      fenp_pkg::ChLoP: pidx = 3'd0;
      fenp_pkg::ChLoN: pidx = 3'd1;
      fenp_pkg::ChLoB: pidx = 3'd2;
      fenp_pkg::ChLoR: pidx = 3'd3;
      fenp_pkg::ChLoQ: pidx = 3'd4;
      fenp_pkg::ChLoK: pidx = 3'd5;
      default: begin
        pidx   = 3'd0;
        pvalid = 1'b0;
      end
    endcase
    dsum     = {1'b0, cur.cursor} + {5'd0, char_code[3:0]};
    sq_bit   = 64'd1 << cur.cursor[5:0];
    acc_x10  = {1'b0, cur.half_acc, 3'd0} + {3'd0, cur.half_acc, 1'b0};
    acc_sum  = {1'b0, acc_x10} + {11'd0, char_code[3:0]};
    rank_ofs = char_code - fenp_pkg::ChOne;
    file_ofs = cur.ep_file - fenp_pkg::ChLoA;
  end

  assign do_board  = (cur.phase == fenp_pkg::PH_BOARD) ||
                     ((cur.phase == fenp_pkg::PH_LEAD) && (char_code != fenp_pkg::ChSpace));
  assign do_castle = (cur.phase == fenp_pkg::PH_CASTLE) ||
                     ((cur.phase == fenp_pkg::PH_SKIP_CASTLE) &&
                      (char_code != fenp_pkg::ChSpace));

  // advance the state by one character; hold everything once in error
  always_comb begin
    nxt = cur;
    if (!cur.err) begin
      if (do_board) begin
        nxt.phase = fenp_pkg::PH_BOARD;
        if (is_digit) begin
          if (dsum[8]) nxt.err = 1'b1;
          else         nxt.cursor = dsum[7:0];
        end else if (is_alpha) begin
          if (!pvalid || (cur.cursor > 8'd63)) begin
            nxt.err = 1'b1;
          end else begin
            nxt.planes[pidx]               = cur.planes[pidx] | sq_bit;
            nxt.planes[fenp_pkg::PlaneOcc] = cur.planes[fenp_pkg::PlaneOcc] | sq_bit;
            if (is_upper) begin
              nxt.planes[fenp_pkg::PlaneWhite] = cur.planes[fenp_pkg::PlaneWhite] | sq_bit;
            end
            nxt.cursor = cur.cursor + 8'd1;
          end
        end else if (char_code == fenp_pkg::ChSlash) begin
          if (cur.cursor[2:0] != 3'd0)              nxt.err = 1'b1;
          else if (cur.cursor < fenp_pkg::RankDrop) nxt.phase = fenp_pkg::PH_NEED_SPACE;
          else                                      nxt.cursor = cur.cursor - fenp_pkg::RankDrop;
        end else if (char_code == fenp_pkg::ChSpace) begin
          if (cur.cursor == fenp_pkg::LastRankEnd) nxt.phase = fenp_pkg::PH_SKIP_TURN;
          else                                     nxt.err = 1'b1;
        end
      end else if (do_castle) begin
        nxt.phase = fenp_pkg::PH_CASTLE;
        if (char_code == fenp_pkg::ChSpace) begin
          nxt.phase = fenp_pkg::PH_SKIP_EP;
        end else if (cur.castle_count < fenp_pkg::CastleLimit) begin
          if ((cur.castle_count == 3'd0) && (char_code == fenp_pkg::ChDash)) begin
            nxt.castle_count = fenp_pkg::CastleSkip;
          end else begin
            nxt.castle_count = cur.castle_count + 3'd1;
            case (char_code)
              fenp_pkg::ChUpK: nxt.castle[0] = 1'b1;
              fenp_pkg::ChUpQ: nxt.castle[1] = 1'b1;
              fenp_pkg::ChLoK: nxt.castle[2] = 1'b1;
              fenp_pkg::ChLoQ: nxt.castle[3] = 1'b1;
              default: begin
                nxt.err          = 1'b1;
                nxt.castle_count = cur.castle_count;
              end
            endcase
          end
        end
      end else begin
        case (cur.phase)
          fenp_pkg::PH_NEED_SPACE: begin
            if (char_code == fenp_pkg::ChSpace) nxt.phase = fenp_pkg::PH_SKIP_TURN;
            else                                nxt.err = 1'b1;
          end
          fenp_pkg::PH_SKIP_TURN: begin
            if (char_code != fenp_pkg::ChSpace) begin
              nxt.side  = (char_code == fenp_pkg::ChW);
              nxt.phase = fenp_pkg::PH_SKIP_CASTLE;
            end
          end
          fenp_pkg::PH_SKIP_EP: begin
            if (char_code == fenp_pkg::ChDash) begin
              nxt.ep_target = fenp_pkg::NoSquare;
              nxt.phase     = fenp_pkg::PH_EP_REST;
            end else if (char_code != fenp_pkg::ChSpace) begin
              nxt.ep_file = char_code;
              nxt.phase   = fenp_pkg::PH_EP_SECOND;
            end
          end
          fenp_pkg::PH_EP_SECOND: begin
            if ((cur.ep_file >= fenp_pkg::ChLoA) && (cur.ep_file <= fenp_pkg::ChLoH) &&
                (char_code >= fenp_pkg::ChOne) && (char_code <= fenp_pkg::ChEight)) begin
              nxt.ep_target = {1'b0, rank_ofs[2:0], file_ofs[2:0]};
              nxt.phase     = fenp_pkg::PH_EP_REST;
            end else begin
              nxt.err = 1'b1;
            end
          end
          fenp_pkg::PH_EP_REST: begin
            if (char_code == fenp_pkg::ChSpace) nxt.phase = fenp_pkg::PH_SKIP_HALF;
          end
          fenp_pkg::PH_SKIP_HALF: begin
            if (is_digit) begin
              nxt.half_acc = {6'd0, char_code[3:0]};
              nxt.phase    = fenp_pkg::PH_HALF;
            end else if (char_code != fenp_pkg::ChSpace) begin
              nxt.err = 1'b1;
            end
          end
          fenp_pkg::PH_HALF: begin
            if (is_digit) begin
              nxt.half_acc = (acc_sum > {5'd0, fenp_pkg::ClockMax}) ?
                             fenp_pkg::ClockMax : acc_sum[9:0];
            end else begin
              nxt.phase = fenp_pkg::PH_DONE;
            end
          end
          default: begin
            nxt = cur;
          end
        endcase
      end
    end
  end

endmodule
